// File: hw/rtl/opl_pkg.sv
package opl_pkg;

	// Geometry of the tree and the stores
	localparam int COORD_BITS        = 10;
	localparam int TWIG_BITS         = 2;
	localparam int NODE_ADDR_BITS    = 12;
	localparam int BRICK_ADDR_BITS   = 14;
	localparam int MAX_BRANCH_LEVELS = COORD_BITS - TWIG_BITS;
	localparam int VOXEL_BITS        = 3 * TWIG_BITS;
	localparam int LEVEL_W           = $clog2(MAX_BRANCH_LEVELS + 1);

	// Port field widths
	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 14;
	localparam int POINT_W = 10;
	localparam int KIND_W  = 2;
	localparam int PAY_W   = 16;
	localparam int NODE_W  = KIND_W + PAY_W;
	localparam int BRICK_W = 16;

	// Transaction modes
	localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NODE_WR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BRICK_WR = 2'd2;

	// Node kinds
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LEAF   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BRICK  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BRANCH = 2'd3;

	typedef struct packed {
		logic                      we;
		logic [NODE_ADDR_BITS-1:0] waddr;
		logic [NODE_W-1:0]         wdata;
		logic                      re;
		logic [NODE_ADDR_BITS-1:0] raddr;
	} node_req_t;

	typedef struct packed {
		logic                       we;
		logic [BRICK_ADDR_BITS-1:0] waddr;
		logic [BRICK_W-1:0]         wdata;
		logic                       re;
		logic [BRICK_ADDR_BITS-1:0] raddr;
	} brick_req_t;

	typedef struct packed {
		logic [PAY_W-1:0] material;
		logic             fault;
	} result_t;

endpackage

// File: hw/rtl/opl_ram.sv
module opl_ram #(
	parameter int ADDR_BITS = 4,
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [(2**ADDR_BITS)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/opl_walker.sv
module opl_walker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [opl_pkg::MODE_W-1:0]            mode,
	input  logic [opl_pkg::ADDR_W-1:0]            addr,
	input  logic [opl_pkg::POINT_W-1:0]           point_x,
	input  logic [opl_pkg::POINT_W-1:0]           point_y,
	input  logic [opl_pkg::POINT_W-1:0]           point_z,
	input  logic [opl_pkg::KIND_W-1:0]            node_kind,
	input  logic [opl_pkg::PAY_W-1:0]             payload,
	output opl_pkg::node_req_t                    node_req,
	input  logic [opl_pkg::NODE_W-1:0]            node_rdata,
	output opl_pkg::brick_req_t                   brick_req,
	input  logic [opl_pkg::BRICK_W-1:0]           brick_rdata,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output opl_pkg::result_t                      res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_NODE  = 2'd1;
	localparam logic [1:0] ST_BRICK = 2'd2;
	localparam logic [1:0] ST_RESP  = 2'd3;

	localparam int CHILD_W  = opl_pkg::PAY_W + 1;
	localparam int BFULL_W  = opl_pkg::PAY_W + opl_pkg::VOXEL_BITS;

	logic [1:0]                         state_q, state_d;
	logic [opl_pkg::LEVEL_W-1:0]        level_q, level_d;
	logic [opl_pkg::COORD_BITS-1:0]     cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
	opl_pkg::result_t                   res_q, res_d;

	logic [opl_pkg::KIND_W-1:0]         kind;
	logic [opl_pkg::PAY_W-1:0]          pay;
	logic [2:0]                         octant;
	logic [CHILD_W-1:0]                 child;
	logic [opl_pkg::VOXEL_BITS-1:0]     voxel;
	logic [BFULL_W-1:0]                 brick_full;

	// Coordinates are kept shifted so the next unused bits sit at the top
	assign kind   = node_rdata[opl_pkg::NODE_W-1 -: opl_pkg::KIND_W];
	assign pay    = node_rdata[opl_pkg::PAY_W-1:0];
	assign octant = {cz_q[opl_pkg::COORD_BITS-1], cy_q[opl_pkg::COORD_BITS-1],
		cx_q[opl_pkg::COORD_BITS-1]};
	assign child  = {1'b0, pay} + CHILD_W'(octant);
	assign voxel  = {cz_q[opl_pkg::COORD_BITS-1 -: opl_pkg::TWIG_BITS],
		cy_q[opl_pkg::COORD_BITS-1 -: opl_pkg::TWIG_BITS],
		cx_q[opl_pkg::COORD_BITS-1 -: opl_pkg::TWIG_BITS]};
	assign brick_full = {pay, voxel};

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		cx_d      = cx_q;
		cy_d      = cy_q;
		cz_d      = cz_q;
		res_d     = res_q;
		node_req  = '0;
		brick_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_d   = '0;
					state_d = ST_RESP;
					case (mode)
						opl_pkg::MODE_QUERY: begin
							cx_d    = point_x[opl_pkg::COORD_BITS-1:0];
							cy_d    = point_y[opl_pkg::COORD_BITS-1:0];
							cz_d    = point_z[opl_pkg::COORD_BITS-1:0];
							level_d = '0;
							if ((addr >> opl_pkg::NODE_ADDR_BITS) == '0) begin
								node_req.re    = 1'b1;
								node_req.raddr = addr[opl_pkg::NODE_ADDR_BITS-1:0];
								state_d        = ST_NODE;
							end else begin
								res_d.fault = 1'b1;
							end
						end
						opl_pkg::MODE_NODE_WR: begin
							if ((addr >> opl_pkg::NODE_ADDR_BITS) == '0) begin
								node_req.we    = 1'b1;
								node_req.waddr = addr[opl_pkg::NODE_ADDR_BITS-1:0];
								node_req.wdata = {node_kind, payload};
							end else begin
								res_d.fault = 1'b1;
							end
						end
						opl_pkg::MODE_BRICK_WR: begin
							if ((addr >> opl_pkg::BRICK_ADDR_BITS) == '0) begin
								brick_req.we    = 1'b1;
								brick_req.waddr = addr[opl_pkg::BRICK_ADDR_BITS-1:0];
								brick_req.wdata = payload;
							end else begin
								res_d.fault = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_NODE: begin
				res_d   = '0;
				state_d = ST_RESP;
				case (kind)
					opl_pkg::KIND_EMPTY: begin
					end
					opl_pkg::KIND_LEAF: begin
						res_d.material = pay;
					end
					opl_pkg::KIND_BRICK: begin
						if ((brick_full >> opl_pkg::BRICK_ADDR_BITS) == '0) begin
							brick_req.re    = 1'b1;
							brick_req.raddr = brick_full[opl_pkg::BRICK_ADDR_BITS-1:0];
							state_d         = ST_BRICK;
						end else begin
							res_d.fault = 1'b1;
						end
					end
					default: begin
						// branch: descend one level or stop on depth/range
						if (level_q >= opl_pkg::LEVEL_W'(opl_pkg::MAX_BRANCH_LEVELS)) begin
							res_d.fault = 1'b1;
						end else if ((child >> opl_pkg::NODE_ADDR_BITS) == '0) begin
							node_req.re    = 1'b1;
							node_req.raddr = child[opl_pkg::NODE_ADDR_BITS-1:0];
							level_d        = opl_pkg::LEVEL_W'(level_q + 1'b1);
							cx_d           = {cx_q[opl_pkg::COORD_BITS-2:0], 1'b0};
							cy_d           = {cy_q[opl_pkg::COORD_BITS-2:0], 1'b0};
							cz_d           = {cz_q[opl_pkg::COORD_BITS-2:0], 1'b0};
							state_d        = ST_NODE;
						end else begin
							res_d.fault = 1'b1;
						end
					end
				endcase
			end
			ST_BRICK: begin
				res_d.material = brick_rdata;
				res_d.fault    = 1'b0;
				state_d        = ST_RESP;
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		cx_q  <= cx_d;
		cy_q  <= cy_d;
		cz_q  <= cz_d;
		res_q <= res_d;
	end

endmodule

// File: hw/rtl/octree_point_lookup.sv
// Sparse voxel octree point lookup.
// Input channel (in_valid/in_ready) takes one transaction per item: mode 0
// looks up the material at (point_x, point_y, point_z) starting at node addr,
// mode 1 writes node word {node_kind, payload} at addr, mode 2 writes brick
// voxel word payload at addr. Every transaction returns exactly one result on
// the output channel (out_valid/out_ready): material and fault.
// A write goes straight from acceptance to its result; a lookup reads one
// node word per tree level through the single node memory read port, up to 9
// node reads with the default geometry, then one brick word if it ends in a
// brick. Each memory read is registered. A finished result passes from the
// walker's result register into the output register that drives out_valid.
// The output register lets the next transaction be accepted while a result
// still waits; when the receiver stalls with the register full, the walker
// holds its finished result and stops accepting input.
// Reset clears the control state only; both stores are undefined until
// written and need no clearing pass.
module octree_point_lookup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [opl_pkg::MODE_W-1:0]   mode,
	input  logic [opl_pkg::ADDR_W-1:0]   addr,
	input  logic [opl_pkg::POINT_W-1:0]  point_x,
	input  logic [opl_pkg::POINT_W-1:0]  point_y,
	input  logic [opl_pkg::POINT_W-1:0]  point_z,
	input  logic [opl_pkg::KIND_W-1:0]   node_kind,
	input  logic [opl_pkg::PAY_W-1:0]    payload,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [opl_pkg::PAY_W-1:0]    material,
	output logic                         fault
);

	opl_pkg::node_req_t                 node_req;
	opl_pkg::brick_req_t                brick_req;
	logic [opl_pkg::NODE_W-1:0]         node_rdata;
	logic [opl_pkg::BRICK_W-1:0]        brick_rdata;
	opl_pkg::result_t                   res;
	logic                               res_valid;
	logic                               res_ready;

	logic                               out_valid_q;
	opl_pkg::result_t                   out_q;

	// Node store: kind in the top bits, payload below
	opl_ram #(
		.ADDR_BITS(opl_pkg::NODE_ADDR_BITS),
		.DATA_BITS(opl_pkg::NODE_W)
	) u_node_ram (
		.clk   (clk),
		.we    (node_req.we),
		.waddr (node_req.waddr),
		.wdata (node_req.wdata),
		.re    (node_req.re),
		.raddr (node_req.raddr),
		.rdata (node_rdata)
	);

	// Brick store: one material word per voxel
	opl_ram #(
		.ADDR_BITS(opl_pkg::BRICK_ADDR_BITS),
		.DATA_BITS(opl_pkg::BRICK_W)
	) u_brick_ram (
		.clk   (clk),
		.we    (brick_req.we),
		.waddr (brick_req.waddr),
		.wdata (brick_req.wdata),
		.re    (brick_req.re),
		.raddr (brick_req.raddr),
		.rdata (brick_rdata)
	);

	// Sequencer: decodes the transaction, walks the tree, issues the brick read
	opl_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.addr        (addr),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.node_kind   (node_kind),
		.payload     (payload),
		.node_req    (node_req),
		.node_rdata  (node_rdata),
		.brick_req   (brick_req),
		.brick_rdata (brick_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: load when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the receiver takes it
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign material  = out_q.material;
	assign fault     = out_q.fault;

endmodule

// File: bench/tb_octree_point_lookup.sv
module tb_octree_point_lookup;
	import opl_pkg::*;

	// Derived geometry
	localparam int NODE_DEPTH  = 1 << NODE_ADDR_BITS;
	localparam int BRICK_DEPTH = 1 << BRICK_ADDR_BITS;
	localparam int TWIG_SIDE   = 1 << TWIG_BITS;

	// Mode 3 has no function in the block; it answers zero and changes nothing
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int ITEMS_PER_PHASE = 500;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 40;

	// One input transaction plus, for directed rows, the answer read off by hand
	typedef struct packed {
		bit [MODE_W-1:0]  mode;
		bit [ADDR_W-1:0]  addr;
		bit [POINT_W-1:0] px;
		bit [POINT_W-1:0] py;
		bit [POINT_W-1:0] pz;
		bit [KIND_W-1:0]  kind;
		bit [PAY_W-1:0]   pay;
		bit               known;
		bit [PAY_W-1:0]   want_mat;
		bit               want_fault;
	} lookup_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [MODE_W-1:0]   mode;
	logic [ADDR_W-1:0]   addr;
	logic [POINT_W-1:0]  point_x;
	logic [POINT_W-1:0]  point_y;
	logic [POINT_W-1:0]  point_z;
	logic [KIND_W-1:0]   node_kind;
	logic [PAY_W-1:0]    payload;
	logic                out_valid;
	logic                out_ready;
	logic [PAY_W-1:0]    material;
	logic                fault;

	// Shadow copy of both stores, with a written mark per entry so that no
	// lookup is ever sent down a path that touches an undefined word
	logic [NODE_W-1:0]   node_words    [NODE_DEPTH];
	bit                  node_written  [NODE_DEPTH];
	logic [BRICK_W-1:0]  voxel_words   [BRICK_DEPTH];
	bit                  voxel_written [BRICK_DEPTH];

	result_t             pending_results [$];
	int                  mismatch_count = 0;
	int                  results_seen   = 0;
	int                  idle_pct       = 0;
	int                  stall_pct      = 0;
	bit                  hold_req       = 1'b0;

	octree_point_lookup DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.addr      (addr),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.node_kind (node_kind),
		.payload   (payload),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.material  (material),
		.fault     (fault)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Directed rows. Node 0 is a branch over nodes 8..15, one child of each
	// sort: full leaf, empty, brick 0, a branch that loops back onto 8..15,
	// zero leaf, the topmost brick, a brick past the store, and a branch most of
	// whose children fall off the node store.
	lookup_row_t directed_rows [0:24] = '{
		'{MODE_NODE_WR, 14'd0, 10'h000, 10'h000, 10'h000, KIND_BRANCH, 16'h0008, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd8, 10'h000, 10'h000, 10'h000, KIND_LEAF, 16'hFFFF, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd9, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'h1234, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd10, 10'h000, 10'h000, 10'h000, KIND_BRICK, 16'h0000, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd11, 10'h000, 10'h000, 10'h000, KIND_BRANCH, 16'h0008, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd12, 10'h000, 10'h000, 10'h000, KIND_LEAF, 16'h0000, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd13, 10'h000, 10'h000, 10'h000, KIND_BRICK, 16'd255, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd14, 10'h000, 10'h000, 10'h000, KIND_BRICK, 16'd256, 1, 16'h0, 0},
		'{MODE_NODE_WR, 14'd15, 10'h000, 10'h000, 10'h000, KIND_BRANCH, 16'd4094, 1, 16'h0, 0},
		'{MODE_BRICK_WR, 14'd0, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'hA5A5, 1, 16'h0, 0},
		'{MODE_BRICK_WR, 14'd63, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'h5A5A, 1, 16'h0, 0},
		'{MODE_BRICK_WR, 14'h3FFF, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'hFFFF, 1, 16'h0, 0},
		// node write past the store: dropped, flagged
		'{MODE_NODE_WR, 14'h3FFF, 10'h3FF, 10'h3FF, 10'h3FF, KIND_BRANCH, 16'hFFFF, 1, 16'h0, 1},
		'{MODE_UNUSED, 14'h3FFF, 10'h3FF, 10'h3FF, 10'h3FF, KIND_BRANCH, 16'hFFFF, 1, 16'h0, 0},
		// start node past the store
		'{MODE_QUERY, 14'h3FFF, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'h0000, 1, 16'h0, 1},
		'{MODE_QUERY, 14'd0, 10'h000, 10'h000, 10'h000, KIND_EMPTY, 16'h0000, 1, 16'hFFFF, 0},
		'{MODE_QUERY, 14'd0, 10'h200, 10'h000, 10'h000, KIND_EMPTY, 16'h0000, 1, 16'h0, 0},
		'{MODE_QUERY, 14'd0, 10'h000, 10'h200, 10'h000, KIND_EMPTY, 16'h0000, 0, 16'h0, 0},
		'{MODE_QUERY, 14'd0, 10'h1FF, 10'h3FF, 10'h1FF, KIND_EMPTY, 16'h0000, 0, 16'h0, 0},
		// child 3 at every level keeps looping through node 11 until too deep
		'{MODE_QUERY, 14'd0, 10'h3FF, 10'h3FF, 10'h000, KIND_EMPTY, 16'h0000, 1, 16'h0, 1},
		'{MODE_QUERY, 14'd0, 10'h000, 10'h000, 10'h200, KIND_EMPTY, 16'h0000, 1, 16'h0, 0},
		'{MODE_QUERY, 14'd0, 10'h380, 10'h180, 10'h380, KIND_EMPTY, 16'h0000, 0, 16'h0, 0},
		// brick number past the brick store
		'{MODE_QUERY, 14'd0, 10'h000, 10'h200, 10'h200, KIND_EMPTY, 16'h0000, 1, 16'h0, 1},
		// child index past the node store
		'{MODE_QUERY, 14'd0, 10'h3FF, 10'h3FF, 10'h3FF, KIND_EMPTY, 16'h0000, 1, 16'h0, 1},
		'{MODE_QUERY, 14'd8, 10'h155, 10'h2AA, 10'h0F0, KIND_EMPTY, 16'h0000, 1, 16'hFFFF, 0}
	};

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at result %0d: %s", results_seen, msg);
	endtask

	// Walk the shadow tree from start. Return 0 if the walk would read an
	// entry never written; such a lookup must not be sent.
	function automatic bit walk_point(input logic [ADDR_W-1:0] start,
			input logic [POINT_W-1:0] px, input logic [POINT_W-1:0] py,
			input logic [POINT_W-1:0] pz, output result_t res);
		int unsigned node;
		int          lvl;
		int          sh;
		int unsigned vox;
		int unsigned slot;
		logic [KIND_W-1:0] kind;
		logic [PAY_W-1:0]  pay;
		logic [2:0]        child;
		node = start;
		res  = '0;
		for (lvl = 0; lvl <= MAX_BRANCH_LEVELS; lvl++) begin
			if (node >= NODE_DEPTH) begin
				res.fault = 1'b1;
				return 1'b1;
			end
			if (!node_written[node])
				return 1'b0;
			kind = node_words[node][PAY_W +: KIND_W];
			pay  = node_words[node][PAY_W-1:0];
			case (kind)
				KIND_EMPTY: return 1'b1;
				KIND_LEAF: begin
					res.material = pay;
					return 1'b1;
				end
				KIND_BRICK: begin
					// Brick takes the next TWIG_BITS bits of each axis
					sh   = MAX_BRANCH_LEVELS - lvl;
					vox  = ((int'(pz) >> sh) & (TWIG_SIDE - 1)) * TWIG_SIDE * TWIG_SIDE
					     + ((int'(py) >> sh) & (TWIG_SIDE - 1)) * TWIG_SIDE
					     + ((int'(px) >> sh) & (TWIG_SIDE - 1));
					slot = (int'(pay) << VOXEL_BITS) + vox;
					if (slot >= BRICK_DEPTH) begin
						res.fault = 1'b1;
						return 1'b1;
					end
					if (!voxel_written[slot])
						return 1'b0;
					res.material = voxel_words[slot];
					return 1'b1;
				end
				default: begin
					if (lvl >= MAX_BRANCH_LEVELS) begin
						res.fault = 1'b1;
						return 1'b1;
					end
					sh    = COORD_BITS - 1 - lvl;
					child = {pz[sh], py[sh], px[sh]};
					node  = int'(pay) + child;
				end
			endcase
		end
		return 1'b1;
	endfunction

	// Apply one accepted transaction to the shadow stores and return its answer
	function automatic result_t commit_transaction(input lookup_row_t t);
		result_t res;
		res = '0;
		case (t.mode)
			MODE_QUERY: void'(walk_point(t.addr, t.px, t.py, t.pz, res));
			MODE_NODE_WR: begin
				if (t.addr < NODE_DEPTH) begin
					node_words[t.addr]   = {t.kind, t.pay};
					node_written[t.addr] = 1'b1;
				end else begin
					res.fault = 1'b1;
				end
			end
			MODE_BRICK_WR: begin
				if (t.addr < BRICK_DEPTH) begin
					voxel_words[t.addr]   = t.pay;
					voxel_written[t.addr] = 1'b1;
				end else begin
					res.fault = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Random transaction. Node writes cluster in a low window (deep trees, loops)
	// and a high window (children falling off the store); brick numbers are mostly
	// small or near the top of the brick store. Lookups are retried until the
	// walk stays on written entries, else a brick write goes instead.
	function automatic lookup_row_t draw_transaction();
		lookup_row_t t;
		result_t     probe;
		int          r;
		int          tries;
		t = '0;
		r = $urandom_range(99);
		if (r >= 48) begin
			t.mode = MODE_QUERY;
			for (tries = 0; tries < 12; tries++) begin
				r = $urandom_range(99);
				if (r < 45)
					t.addr = $urandom_range(63);
				else if (r < 85)
					t.addr = $urandom_range(NODE_DEPTH - 1, NODE_DEPTH - 32);
				else if (r < 95)
					t.addr = $urandom_range(NODE_DEPTH - 1);
				else
					t.addr = $urandom_range((1 << ADDR_W) - 1, NODE_DEPTH);
				t.px = $urandom;
				t.py = $urandom;
				t.pz = $urandom;
				if (walk_point(t.addr, t.px, t.py, t.pz, probe))
					return t;
			end
			r = 30;
		end
		if (r < 30) begin
			t.mode = MODE_NODE_WR;
			r = $urandom_range(99);
			if (r < 45)
				t.addr = $urandom_range(63);
			else if (r < 80)
				t.addr = $urandom_range(NODE_DEPTH - 1, NODE_DEPTH - 32);
			else
				t.addr = $urandom;
			r = $urandom_range(99);
			if (r < 35) begin
				t.kind = KIND_BRANCH;
				r = $urandom_range(99);
				if (r < 40)
					t.pay = $urandom_range(56);
				else if (r < 75)
					t.pay = $urandom_range(NODE_DEPTH - 1, NODE_DEPTH - 36);
				else
					t.pay = $urandom;
			end else if (r < 85 && r >= 60) begin
				t.kind = KIND_BRICK;
				r = $urandom_range(99);
				if (r < 60)
					t.pay = $urandom_range(3);
				else if (r < 75)
					t.pay = $urandom_range(255, 252);
				else if (r < 85)
					t.pay = $urandom_range(259, 256);
				else
					t.pay = $urandom;
			end else begin
				t.kind = (r < 60) ? KIND_LEAF : KIND_EMPTY;
				t.pay  = $urandom;
			end
		end else if (r < 45) begin
			t.mode = MODE_BRICK_WR;
			r = $urandom_range(99);
			if (r < 50)
				t.addr = $urandom_range(255);
			else if (r < 75)
				t.addr = $urandom_range(BRICK_DEPTH - 1, BRICK_DEPTH - 256);
			else
				t.addr = $urandom;
			t.pay = $urandom;
		end else begin
			// Ignored transaction with noise on every field
			t.mode = MODE_UNUSED;
			t.addr = $urandom;
			t.px   = $urandom;
			t.py   = $urandom;
			t.pz   = $urandom;
			t.kind = $urandom;
			t.pay  = $urandom;
		end
		return t;
	endfunction

	// Offer one transaction, hold it until accepted, then record its answer.
	// Valid drops only when an idle gap comes before the transaction.
	task automatic offer(input lookup_row_t t);
		int      gap = 0;
		result_t got;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= t.mode;
		addr      <= t.addr;
		point_x   <= t.px;
		point_y   <= t.py;
		point_z   <= t.pz;
		node_kind <= t.kind;
		payload   <= t.pay;
		do @(posedge clk); while (in_ready !== 1'b1);
		got = commit_transaction(t);
		if (t.known)
			got = {t.want_mat, t.want_fault};
		pending_results.push_back(got);
	endtask

	// Stop offering and wait until every outstanding answer has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls at the phase rate; on request hold off for a long
	// stretch so the block fills and pushes back on its input
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  <= 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each returned transaction against the oldest outstanding answer
	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("no answer outstanding, got material %h fault %b",
					material, fault));
			end else begin
				want = pending_results.pop_front();
				if (material !== want.material)
					flag_mismatch($sformatf("material %h, predicted %h",
						material, want.material));
				if (fault !== want.fault)
					flag_mismatch($sformatf("fault %b, predicted %b", fault, want.fault));
			end
		end
	end

	initial begin : stimulus
		lookup_row_t t;
		int          phase;
		int          counted;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_QUERY;
		addr      = '0;
		point_x   = '0;
		point_y   = '0;
		point_z   = '0;
		node_kind = KIND_EMPTY;
		payload   = '0;
		repeat (12) @(posedge clk);
		// Release reset away from the active edge
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i]);
		drain_results();

		// Phases: no idling, idle sender, stalling receiver, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			// Long receiver hold while the sender keeps offering back to back
			if (phase == 0)
				hold_req <= 1'b1;
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				t = draw_transaction();
				offer(t);
				if (t.mode != MODE_UNUSED)
					counted++;
			end
			drain_results();
		end

		// Let any stray result show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/opl_pkg.sv
hw/rtl/opl_ram.sv
hw/rtl/opl_walker.sv
hw/rtl/octree_point_lookup.sv
bench/tb_octree_point_lookup.sv
